[design/ptab_pkg.sv]
`default_nettype none

package ptab_pkg;

	localparam int ADDR_W = 32;
	localparam int PORT_W = 16;
	localparam int CD_W   = 16;
	localparam int SLOT_W = 4;
	localparam int CNT_W  = 5;

	localparam logic [CD_W-1:0] AGING_RELOAD_RST = 16'd1000;

	typedef enum logic [1:0] {
		OP_REGISTER = 2'd0,
		OP_TICK     = 2'd1,
		OP_LIST     = 2'd2,
		OP_NONE     = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_REFRESHED  = 3'd0,
		ST_INSERTED   = 3'd1,
		ST_FULL       = 3'd2,
		ST_TICK_DONE  = 3'd3,
		ST_LISTED     = 3'd4,
		ST_LIST_EMPTY = 3'd5
	} status_t;

	typedef enum logic [5:0] {
		S_IDLE      = 6'b000001,
		S_REG_SCAN  = 6'b000010,
		S_REG_DONE  = 6'b000100,
		S_TICK_SCAN = 6'b001000,
		S_TICK_DONE = 6'b010000,
		S_LIST_SCAN = 6'b100000
	} seq_state_t;

	// Write command from the sequencer to the table, one slot per cycle
	typedef struct packed {
		logic            wr_cd;
		logic [CD_W-1:0] cd_val;
		logic            wr_entry;
		logic            set_valid;
		logic            clr_valid;
	} tbl_cmd_t;

	// Contents of the slot selected by the sequencer
	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] addr;
		logic [PORT_W-1:0] port;
		logic [CD_W-1:0]   cd;
	} tbl_rd_t;

	typedef struct packed {
		logic              valid;
		status_t           status;
		logic [SLOT_W-1:0] slot;
		logic [ADDR_W-1:0] addr;
		logic [PORT_W-1:0] port;
		logic [CNT_W-1:0]  expired;
		logic [CNT_W-1:0]  active;
		logic              last;
	} res_t;

endpackage

`default_nettype wire

[design/peer_table_with_aging_unit.sv]
// Channel   Handshake              Words
// input     start / busy           opcode, peer_address, peer_port
// config    aging_reload_we        aging_reload_wdata
// result    done (per-word strobe) status, slot, out_address, out_port,
//                                  expired_count, active_count, last
//
// A register item scans the slots and then a done state, stopping early on a
// match; a tick item scans every slot, then a done state; a list item scans
// up to every slot. Busy is high throughout and start is ignored meanwhile.
// One slot is visited per cycle through the single compare/decrement unit.
// Results appear in the cycle after they are formed, through an output register.
// The receiver cannot stall: each word is shown with done for a single cycle;
// list words may be back to back. No clearing pass: valid bits reset at once.
`default_nettype none

module peer_table_with_aging_unit #(
	parameter int ENTRIES = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  opcode,
	input  wire logic [31:0] peer_address,
	input  wire logic [15:0] peer_port,
	input  wire logic        aging_reload_we,
	input  wire logic [15:0] aging_reload_wdata,
	output logic             done,
	output logic [2:0]       status,
	output logic [3:0]       slot,
	output logic [31:0]      out_address,
	output logic [15:0]      out_port,
	output logic [4:0]       expired_count,
	output logic [4:0]       active_count,
	output logic             last
);
	import ptab_pkg::*;

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic [CD_W-1:0]   aging_reload_q;
	logic [IW-1:0]     tbl_slot;
	tbl_cmd_t          tbl_cmd;
	tbl_rd_t           tbl_rd;
	logic [CNT_W-1:0]  active_cnt;
	logic [ADDR_W-1:0] key_addr;
	logic [PORT_W-1:0] key_port;
	res_t              res;

	// Reload value: the user must write it only while idle so the sequencer sees it stable; not enforced here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aging_reload_q <= AGING_RELOAD_RST;
		end else if (aging_reload_we) begin
			aging_reload_q <= aging_reload_wdata;
		end
	end

	// Sequencer: walks the slots one per cycle and forms each result word
	ptab_seq #(
		.ENTRIES(ENTRIES),
		.IW     (IW)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.opcode      (opcode),
		.peer_address(peer_address),
		.peer_port   (peer_port),
		.aging_reload(aging_reload_q),
		.rd          (tbl_rd),
		.active_cnt  (active_cnt),
		.busy        (busy),
		.slot        (tbl_slot),
		.cmd         (tbl_cmd),
		.key_addr    (key_addr),
		.key_port    (key_port),
		.res         (res)
	);

	// Table storage: valid bits, countdowns, endpoints and the active count
	ptab_table #(
		.ENTRIES(ENTRIES),
		.IW     (IW)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.slot      (tbl_slot),
		.cmd       (tbl_cmd),
		.wr_addr   (key_addr),
		.wr_port   (key_port),
		.rd        (tbl_rd),
		.active_cnt(active_cnt)
	);

	// Output register: the strobe resets, the payload just follows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			status        <= res.status;
			slot          <= res.slot;
			out_address   <= res.addr;
			out_port      <= res.port;
			expired_count <= res.expired;
			active_count  <= res.active;
			last          <= res.last;
		end
	end

endmodule

`default_nettype wire

[design/ptab_table.sv]
`default_nettype none

module ptab_table #(
	parameter int ENTRIES = 4,
	parameter int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [IW-1:0]             slot,
	input  wire ptab_pkg::tbl_cmd_t        cmd,
	input  wire logic [ptab_pkg::ADDR_W-1:0] wr_addr,
	input  wire logic [ptab_pkg::PORT_W-1:0] wr_port,
	output ptab_pkg::tbl_rd_t              rd,
	output logic [ptab_pkg::CNT_W-1:0]     active_cnt
);
	import ptab_pkg::*;

	logic [ENTRIES-1:0] valid_q;
	logic [CD_W-1:0]    cd_q   [ENTRIES];
	logic [ADDR_W-1:0]  addr_q [ENTRIES];
	logic [PORT_W-1:0]  port_q [ENTRIES];
	logic [CNT_W-1:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			cnt_q   <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				cd_q[i] <= '0;
			end
		end else begin
			if (cmd.set_valid) begin
				valid_q[slot] <= 1'b1;
				cnt_q         <= cnt_q + CNT_W'(1);
			end else if (cmd.clr_valid) begin
				valid_q[slot] <= 1'b0;
				cnt_q         <= cnt_q - CNT_W'(1);
			end
			if (cmd.wr_cd) begin
				cd_q[slot] <= cmd.cd_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_entry) begin
			addr_q[slot] <= wr_addr;
			port_q[slot] <= wr_port;
		end
	end

	assign rd.valid   = valid_q[slot];
	assign rd.addr    = addr_q[slot];
	assign rd.port    = port_q[slot];
	assign rd.cd      = cd_q[slot];
	assign active_cnt = cnt_q;

endmodule

`default_nettype wire

[design/ptab_seq.sv]
`default_nettype none

module ptab_seq #(
	parameter int ENTRIES = 4,
	parameter int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [1:0]                  opcode,
	input  wire logic [ptab_pkg::ADDR_W-1:0] peer_address,
	input  wire logic [ptab_pkg::PORT_W-1:0] peer_port,
	input  wire logic [ptab_pkg::CD_W-1:0]   aging_reload,
	input  wire ptab_pkg::tbl_rd_t           rd,
	input  wire logic [ptab_pkg::CNT_W-1:0]  active_cnt,
	output logic                             busy,
	output logic [IW-1:0]                    slot,
	output ptab_pkg::tbl_cmd_t               cmd,
	output logic [ptab_pkg::ADDR_W-1:0]      key_addr,
	output logic [ptab_pkg::PORT_W-1:0]      key_port,
	output ptab_pkg::res_t                   res
);
	import ptab_pkg::*;

	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

	seq_state_t        state_q, state_d;
	logic [IW-1:0]     idx_q, idx_d;
	logic              free_found_q, free_found_d;
	logic [IW-1:0]     free_slot_q, free_slot_d;
	logic [CNT_W-1:0]  expired_q, expired_d;
	logic [CNT_W-1:0]  k_q, k_d;
	logic [ADDR_W-1:0] addr_q;
	logic [PORT_W-1:0] port_q;

	// shared compare / decrement unit on the selected slot
	logic            match;
	logic            cd_zero;
	logic [CD_W-1:0] cd_dec;
	logic            list_last;

	assign match     = rd.valid && (rd.addr == addr_q) && (rd.port == port_q);
	assign cd_zero   = (rd.cd == '0);
	assign cd_dec    = rd.cd - CD_W'(1);
	assign list_last = ((k_q + CNT_W'(1)) == active_cnt);

	assign busy     = (state_q != S_IDLE);
	assign slot     = (state_q == S_REG_DONE) ? free_slot_q : idx_q;
	assign key_addr = addr_q;
	assign key_port = port_q;

	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		free_found_d = free_found_q;
		free_slot_d  = free_slot_q;
		expired_d    = expired_q;
		k_d          = k_q;
		cmd          = '0;
		res          = '0;
		case (state_q)
			S_IDLE: begin
				idx_d        = '0;
				free_found_d = 1'b0;
				expired_d    = '0;
				k_d          = '0;
				if (start) begin
					case (opcode_t'(opcode))
						OP_REGISTER: state_d = S_REG_SCAN;
						OP_TICK:     state_d = S_TICK_SCAN;
						OP_LIST:     state_d = S_LIST_SCAN;
						default:     state_d = S_IDLE;
					endcase
				end
			end
			S_REG_SCAN: begin
				idx_d = idx_q + IW'(1);
				if (match) begin
					cmd.wr_cd   = 1'b1;
					cmd.cd_val  = aging_reload;
					res.valid   = 1'b1;
					res.status  = ST_REFRESHED;
					res.slot    = SLOT_W'(idx_q);
					res.addr    = addr_q;
					res.port    = port_q;
					res.active  = active_cnt;
					res.last    = 1'b1;
					state_d     = S_IDLE;
				end else begin
					if (!rd.valid && !free_found_q) begin
						free_found_d = 1'b1;
						free_slot_d  = idx_q;
					end
					if (idx_q == LAST_IDX) begin
						state_d = S_REG_DONE;
					end
				end
			end
			S_REG_DONE: begin
				res.valid = 1'b1;
				res.last  = 1'b1;
				if (free_found_q) begin
					cmd.wr_entry  = 1'b1;
					cmd.wr_cd     = 1'b1;
					cmd.set_valid = 1'b1;
					cmd.cd_val    = aging_reload;
					res.status    = ST_INSERTED;
					res.slot      = SLOT_W'(free_slot_q);
					res.addr      = addr_q;
					res.port      = port_q;
					res.active    = active_cnt + CNT_W'(1);
				end else begin
					res.status = ST_FULL;
					res.active = active_cnt;
				end
				state_d = S_IDLE;
			end
			S_TICK_SCAN: begin
				idx_d = idx_q + IW'(1);
				if (rd.valid) begin
					if (cd_zero) begin
						cmd.clr_valid = 1'b1;
						expired_d     = expired_q + CNT_W'(1);
					end else begin
						cmd.wr_cd  = 1'b1;
						cmd.cd_val = cd_dec;
					end
				end
				if (idx_q == LAST_IDX) begin
					state_d = S_TICK_DONE;
				end
			end
			S_TICK_DONE: begin
				res.valid   = 1'b1;
				res.status  = ST_TICK_DONE;
				res.expired = expired_q;
				res.active  = active_cnt;
				res.last    = 1'b1;
				state_d     = S_IDLE;
			end
			S_LIST_SCAN: begin
				idx_d = idx_q + IW'(1);
				if (active_cnt == '0) begin
					res.valid  = 1'b1;
					res.status = ST_LIST_EMPTY;
					res.last   = 1'b1;
					state_d    = S_IDLE;
				end else begin
					if (rd.valid) begin
						res.valid  = 1'b1;
						res.status = ST_LISTED;
						res.slot   = SLOT_W'(idx_q);
						res.addr   = rd.addr;
						res.port   = rd.port;
						res.active = active_cnt;
						res.last   = list_last;
						k_d        = k_q + CNT_W'(1);
					end
					if ((rd.valid && list_last) || (idx_q == LAST_IDX)) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			free_found_q <= 1'b0;
			expired_q    <= '0;
			k_q          <= '0;
		end else begin
			state_q      <= state_d;
			idx_q        <= idx_d;
			free_found_q <= free_found_d;
			expired_q    <= expired_d;
			k_q          <= k_d;
		end
	end

	always_ff @(posedge clk) begin
		free_slot_q <= free_slot_d;
		if (start && !busy) begin
			addr_q <= peer_address;
			port_q <= peer_port;
		end
	end

`ifndef SYNTH
	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.last |=> state_q == S_IDLE)
		else $error("item still busy after its last word");

	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !res.valid && !cmd.wr_cd && !cmd.set_valid && !cmd.clr_valid)
		else $error("word or table write while idle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && opcode_t'(opcode) != OP_NONE |=> busy)
		else $error("accepted word did not start a sequence");

	a_single_word: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.status != ST_LISTED |-> res.last)
		else $error("single-word result without last");

	a_no_grow_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.set_valid |-> active_cnt < CNT_W'(ENTRIES))
		else $error("insert into a full table");
`endif

endmodule

`default_nettype wire
